// ===== src/tanc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tanc_pkg;

   localparam int WORD_W    = 64;
   localparam int HZ_W      = 14;
   localparam int PER_NS_W  = 30;
   localparam int RES_W     = 27;
   localparam int PHASE_W   = 3;
   localparam int REQ_W     = 2;
   localparam int SUB_SHIFT = 10;

   localparam int DIV_STEPS = WORD_W;
   localparam int MUL_STEPS = PER_NS_W;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   localparam int CALIB_TICKS_DEF = 4;

   localparam logic [HZ_W-1:0] HZ_RESET   = 14'd100;
   localparam logic [HZ_W-1:0] HZ_DEFAULT = 14'd100;

   localparam logic [WORD_W-1:0] NS_PER_S  = 64'd1000000000;
   localparam logic [WORD_W-1:0] CAL_LO_HZ = 64'd1000000;
   localparam logic [WORD_W-1:0] CAL_HI_HZ = 64'd100000000000;
   localparam logic [WORD_W-1:0] MS_PER_S  = 64'd1000;

   localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CALIB = 2'd2;

   localparam logic [PHASE_W-1:0] CAL_IDLE   = 3'd0;
   localparam logic [PHASE_W-1:0] CAL_WAIT   = 3'd1;
   localparam logic [PHASE_W-1:0] CAL_COUNT  = 3'd2;
   localparam logic [PHASE_W-1:0] CAL_ACCEPT = 3'd3;
   localparam logic [PHASE_W-1:0] CAL_REJECT = 3'd4;

   typedef enum logic {
      ALU_MUL = 1'b0,
      ALU_DIV = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] result;
   } alu_rsp_type;

endpackage

`default_nettype wire

// ===== src/tick_anchored_ns_clock.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tick-anchored nanosecond clock.
// Requests arrive on req_* (valid/ready): a tick event, a time query or a
// calibration start, each with the current free-running cycle stamp. Every
// request gives exactly one response on rsp_* (valid/ready) holding ns and ms
// since start, resolution, tick total, calibrated flag and calibration phase.
// csr_wr_en/csr_wr_data write the tick rate in Hz (0 reads as 100); write it
// only while no request is in flight.
// All multiplication and division run through one shared unit: a radix-2
// divider (64 steps) and a shift-add multiplier (30 steps). One request is
// in work at a time; req_ready is high only when the sequencer is idle, so
// the next request can be taken in the cycle after the previous response is
// loaded.
// A finished response waits in the output register while the receiver
// stalls; the next request is taken meanwhile and holds in its last step
// until the register frees up.
// Reset: synchronous, active high; clears tick count, last tick stamp,
// calibration and sets the rate to 100 Hz.
module tick_anchored_ns_clock #(
   parameter int CALIB_TICKS = tanc_pkg::CALIB_TICKS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [tanc_pkg::HZ_W-1:0]     csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [tanc_pkg::REQ_W-1:0]    req_type,
   input  wire logic [tanc_pkg::WORD_W-1:0]   req_cycle_stamp,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [tanc_pkg::WORD_W-1:0]        rsp_ns_now,
   output logic [tanc_pkg::WORD_W-1:0]        rsp_ms_now,
   output logic [tanc_pkg::RES_W-1:0]         rsp_res_ns,
   output logic [tanc_pkg::WORD_W-1:0]        rsp_tick_total,
   output logic                               rsp_is_calibrated,
   output logic [tanc_pkg::PHASE_W-1:0]       rsp_calib_state
);
   import tanc_pkg::*;

   localparam int SEEN_W = $clog2(CALIB_TICKS + 1);

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0000000000001,
      ST_CAL_PER = 13'b0000000000010,
      ST_CAL_LO  = 13'b0000000000100,
      ST_CAL_HI  = 13'b0000000001000,
      ST_PERNS   = 13'b0000000010000,
      ST_NS      = 13'b0000000100000,
      ST_MS_MUL  = 13'b0000001000000,
      ST_MS_DIV  = 13'b0000010000000,
      ST_CLAMP   = 13'b0000100000000,
      ST_FR_MUL  = 13'b0001000000000,
      ST_FR_DIV  = 13'b0010000000000,
      ST_RES     = 13'b0100000000000,
      ST_OUT     = 13'b1000000000000
   } state_type;

   function automatic logic uses_alu(input state_type st);
      return st inside {ST_CAL_PER, ST_CAL_LO, ST_CAL_HI, ST_PERNS, ST_NS, ST_MS_MUL,
                        ST_MS_DIV, ST_FR_MUL, ST_FR_DIV, ST_RES};
   endfunction

   state_type            state_ff, state_in;
   logic                 go_ff, go_in;
   logic [HZ_W-1:0]      hz_ff, hz_in;
   logic [WORD_W-1:0]    tick_count_ff, tick_count_in;
   logic [WORD_W-1:0]    last_stamp_ff, last_stamp_in;
   logic [WORD_W-1:0]    cpt_ff, cpt_in;
   logic [SEEN_W-1:0]    seen_ff, seen_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [WORD_W-1:0]    begin_stamp_ff, begin_stamp_in;
   logic [WORD_W-1:0]    stamp_ff, stamp_in;
   logic [WORD_W-1:0]    per_ff, per_in;
   logic [WORD_W-1:0]    tmp_ff, tmp_in;
   logic [PER_NS_W-1:0]  per_ns_ff, per_ns_in;
   logic [WORD_W-1:0]    ns_ff, ns_in;
   logic [WORD_W-1:0]    ms_ff, ms_in;
   logic [RES_W-1:0]     res_ff, res_in;
   logic [WORD_W-1:0]    o_ns_ff, o_ns_in;
   logic [WORD_W-1:0]    o_ms_ff, o_ms_in;
   logic [RES_W-1:0]     o_res_ff, o_res_in;
   logic [WORD_W-1:0]    o_ticks_ff, o_ticks_in;
   logic                 o_cal_ff, o_cal_in;
   logic [PHASE_W-1:0]   o_phase_ff, o_phase_in;

   logic [HZ_W-1:0]      eff_hz;
   logic [WORD_W-1:0]    hz_word;
   logic [WORD_W-1:0]    per_ns_word;
   logic [WORD_W-1:0]    den;
   logic [WORD_W-1:0]    d_raw;
   logic [SEEN_W-1:0]    seen_next;
   alu_cmd_type          alu_cmd;
   alu_rsp_type          alu_rsp;
   logic [WORD_W-1:0]    alu_a;
   logic [WORD_W-1:0]    alu_b;
   logic                 accept;

   assign eff_hz      = (hz_ff == '0) ? HZ_DEFAULT : hz_ff;
   assign hz_word     = WORD_W'(eff_hz);
   assign per_ns_word = WORD_W'(per_ns_ff);
   assign den         = ((cpt_ff >> SUB_SHIFT) == '0) ? WORD_W'(1) : (cpt_ff >> SUB_SHIFT);
   assign d_raw       = stamp_ff - last_stamp_ff;
   assign seen_next   = seen_ff + SEEN_W'(1);
   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;

   // operand select for the shared unit
   always_comb begin
      alu_cmd.start = go_ff;
      alu_cmd.op    = ALU_DIV;
      alu_a         = '0;
      alu_b         = WORD_W'(1);
      case (state_ff)
         ST_CAL_PER: begin
            alu_a = stamp_ff - begin_stamp_ff;
            alu_b = WORD_W'(CALIB_TICKS);
         end
         ST_CAL_LO: begin
            alu_a = CAL_LO_HZ;
            alu_b = hz_word;
         end
         ST_CAL_HI: begin
            alu_a = CAL_HI_HZ;
            alu_b = hz_word;
         end
         ST_PERNS: begin
            alu_a = NS_PER_S;
            alu_b = hz_word;
         end
         ST_NS: begin
            alu_cmd.op = ALU_MUL;
            alu_a      = tick_count_ff;
            alu_b      = per_ns_word;
         end
         ST_MS_MUL: begin
            alu_cmd.op = ALU_MUL;
            alu_a      = tick_count_ff;
            alu_b      = MS_PER_S;
         end
         ST_MS_DIV: begin
            alu_a = tmp_ff;
            alu_b = hz_word;
         end
         ST_FR_MUL: begin
            alu_cmd.op = ALU_MUL;
            alu_a      = tmp_ff >> SUB_SHIFT;
            alu_b      = per_ns_word;
         end
         ST_FR_DIV: begin
            alu_a = tmp_ff;
            alu_b = den;
         end
         ST_RES: begin
            alu_a = per_ns_word;
            alu_b = cpt_ff;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   tanc_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .opa   (alu_a),
      .opb   (alu_b),
      .rsp   (alu_rsp)
   );

   always_comb begin
      state_in       = state_ff;
      hz_in          = csr_wr_en ? csr_wr_data : hz_ff;
      tick_count_in  = tick_count_ff;
      last_stamp_in  = last_stamp_ff;
      cpt_in         = cpt_ff;
      seen_in        = seen_ff;
      phase_in       = phase_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      begin_stamp_in = begin_stamp_ff;
      stamp_in       = stamp_ff;
      per_in         = per_ff;
      tmp_in         = tmp_ff;
      per_ns_in      = per_ns_ff;
      ns_in          = ns_ff;
      ms_in          = ms_ff;
      res_in         = res_ff;
      o_ns_in        = o_ns_ff;
      o_ms_in        = o_ms_ff;
      o_res_in       = o_res_ff;
      o_ticks_in     = o_ticks_ff;
      o_cal_in       = o_cal_ff;
      o_phase_in     = o_phase_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               stamp_in = req_cycle_stamp;
               state_in = ST_PERNS;
               case (req_type)
                  REQ_TICK: begin
                     tick_count_in = tick_count_ff + WORD_W'(1);
                     last_stamp_in = req_cycle_stamp;
                     if (phase_ff == CAL_WAIT) begin
                        begin_stamp_in = req_cycle_stamp;
                        seen_in        = '0;
                        phase_in       = CAL_COUNT;
                     end else if (phase_ff == CAL_COUNT) begin
                        seen_in = seen_next;
                        if (seen_next >= SEEN_W'(CALIB_TICKS)) begin
                           state_in = ST_CAL_PER;
                        end
                     end
                  end
                  REQ_CALIB: begin
                     phase_in = CAL_WAIT;
                     seen_in  = '0;
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end
         ST_CAL_PER: begin
            if (alu_rsp.done) begin
               per_in   = alu_rsp.result;
               state_in = ST_CAL_LO;
            end
         end
         ST_CAL_LO: begin
            if (alu_rsp.done) begin
               tmp_in   = alu_rsp.result;
               state_in = ST_CAL_HI;
            end
         end
         ST_CAL_HI: begin
            if (alu_rsp.done) begin
               if (per_ff > tmp_ff && per_ff < alu_rsp.result) begin
                  cpt_in   = per_ff;
                  phase_in = CAL_ACCEPT;
               end else begin
                  phase_in = CAL_REJECT;
               end
               state_in = ST_PERNS;
            end
         end
         ST_PERNS: begin
            if (alu_rsp.done) begin
               per_ns_in = alu_rsp.result[PER_NS_W-1:0];
               state_in  = ST_NS;
            end
         end
         ST_NS: begin
            if (alu_rsp.done) begin
               ns_in    = alu_rsp.result;
               state_in = ST_MS_MUL;
            end
         end
         ST_MS_MUL: begin
            if (alu_rsp.done) begin
               tmp_in   = alu_rsp.result;
               state_in = ST_MS_DIV;
            end
         end
         ST_MS_DIV: begin
            if (alu_rsp.done) begin
               ms_in = alu_rsp.result;
               if (cpt_ff == '0) begin
                  res_in   = per_ns_ff[RES_W-1:0];
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_CLAMP;
               end
            end
         end
         ST_CLAMP: begin
            tmp_in   = (d_raw >= cpt_ff) ? (cpt_ff - WORD_W'(1)) : d_raw;
            state_in = ST_FR_MUL;
         end
         ST_FR_MUL: begin
            if (alu_rsp.done) begin
               tmp_in   = alu_rsp.result;
               state_in = ST_FR_DIV;
            end
         end
         ST_FR_DIV: begin
            if (alu_rsp.done) begin
               ns_in    = ns_ff + alu_rsp.result;
               state_in = ST_RES;
            end
         end
         ST_RES: begin
            if (alu_rsp.done) begin
               res_in   = (alu_rsp.result == '0) ? RES_W'(1) : alu_rsp.result[RES_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               o_ns_in      = ns_ff;
               o_ms_in      = ms_ff;
               o_res_in     = res_ff;
               o_ticks_in   = tick_count_ff;
               o_cal_in     = (cpt_ff != '0);
               o_phase_in   = phase_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      go_in = (state_in != state_ff) && uses_alu(state_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         go_ff         <= 1'b0;
         hz_ff         <= HZ_RESET;
         tick_count_ff <= '0;
         last_stamp_ff <= '0;
         cpt_ff        <= '0;
         seen_ff       <= '0;
         phase_ff      <= CAL_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         go_ff         <= go_in;
         hz_ff         <= hz_in;
         tick_count_ff <= tick_count_in;
         last_stamp_ff <= last_stamp_in;
         cpt_ff        <= cpt_in;
         seen_ff       <= seen_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      begin_stamp_ff <= begin_stamp_in;
      stamp_ff       <= stamp_in;
      per_ff         <= per_in;
      tmp_ff         <= tmp_in;
      per_ns_ff      <= per_ns_in;
      ns_ff          <= ns_in;
      ms_ff          <= ms_in;
      res_ff         <= res_in;
      o_ns_ff        <= o_ns_in;
      o_ms_ff        <= o_ms_in;
      o_res_ff       <= o_res_in;
      o_ticks_ff     <= o_ticks_in;
      o_cal_ff       <= o_cal_in;
      o_phase_ff     <= o_phase_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ns_now        = o_ns_ff;
   assign rsp_ms_now        = o_ms_ff;
   assign rsp_res_ns        = o_res_ff;
   assign rsp_tick_total    = o_ticks_ff;
   assign rsp_is_calibrated = o_cal_ff;
   assign rsp_calib_state   = o_phase_ff;

endmodule

`default_nettype wire

// ===== src/tanc_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tanc_alu (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tanc_pkg::alu_cmd_type       cmd,
   input  wire logic [tanc_pkg::WORD_W-1:0] opa,
   input  wire logic [tanc_pkg::WORD_W-1:0] opb,
   output tanc_pkg::alu_rsp_type            rsp
);
   import tanc_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   alu_op_type        op_ff, op_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] x_ff, x_in;
   logic [WORD_W-1:0] y_ff, y_in;

   logic [WORD_W:0]   rem_sh;
   logic [WORD_W:0]   add_a;
   logic [WORD_W:0]   add_b;
   logic              add_cin;
   logic [WORD_W+1:0] sum;
   logic              ge;

   // one shared adder: trial subtract for divide, accumulate for multiply
   always_comb begin
      rem_sh = {acc_ff, x_ff[WORD_W-1]};
      if (op_ff == ALU_DIV) begin
         add_a   = rem_sh;
         add_b   = ~{1'b0, y_ff};
         add_cin = 1'b1;
      end else begin
         add_a   = {1'b0, acc_ff};
         add_b   = y_ff[0] ? {1'b0, x_ff} : '0;
         add_cin = 1'b0;
      end
      sum = {1'b0, add_a} + {1'b0, add_b} + {{(WORD_W+1){1'b0}}, add_cin};
      ge  = sum[WORD_W+1];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         acc_in  = '0;
         x_in    = opa;
         y_in    = opb;
         cnt_in  = (cmd.op == ALU_DIV) ? CNT_W'(DIV_STEPS) : CNT_W'(MUL_STEPS);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (op_ff == ALU_DIV) begin
            acc_in = ge ? sum[WORD_W-1:0] : rem_sh[WORD_W-1:0];
            x_in   = {x_ff[WORD_W-2:0], ge};
         end else begin
            acc_in = sum[WORD_W-1:0];
            x_in   = {x_ff[WORD_W-2:0], 1'b0};
            y_in   = {1'b0, y_ff[WORD_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = (op_ff == ALU_DIV) ? x_ff : acc_ff;

endmodule

`default_nettype wire
